[hdl/tes_pkg.sv]
// Shared types and constants for the 64-bit timer extension and alarm scheduler.
`timescale 1ns / 1ps

package tes_pkg;

    localparam int          CounterWidthDefault = 32;
    localparam logic [31:0] PartitionSizeReset  = 32'h0000_4000;
    localparam logic [31:0] CounterMaskReset    = 32'hFFFF_FFFF;
    localparam logic [63:0] TargetUnset         = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_EVENT = 2'd0,
        KIND_REL   = 2'd1,
        KIND_ABS   = 2'd2,
        KIND_READ  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CFG_PARTITION_SIZE = 2'd0,
        CFG_COUNTER_MASK   = 2'd1
    } t_cfg_index;

    // Item handed from the time extension to the alarm logic
    typedef struct packed {
        t_kind       kind;
        logic [31:0] reading;
        logic [63:0] operand;
        logic [63:0] now;
        logic [63:0] rel_target;
    } t_ext_item;

endpackage

[hdl/tes_extend.sv]
// Counter extension: input register, partition tracking and 64-bit time.
`timescale 1ns / 1ps

module tes_extend #(
    parameter int COUNTER_WIDTH = tes_pkg::CounterWidthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_kind,
    input  logic [31:0]         i_lower_count,
    input  logic [63:0]         i_operand_value,
    input  logic [31:0]         i_partition_size,
    input  logic [31:0]         i_counter_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output tes_pkg::t_ext_item  o_item
);
    import tes_pkg::*;

    localparam logic [31:0] WidthMask = 32'((64'd1 << COUNTER_WIDTH) - 64'd1);

    // input register
    logic        r_0_v;
    t_kind       r_0_kind;
    logic [31:0] r_0_reading;
    logic [63:0] r_0_op;

    // partition stage
    logic        r_a_v;
    t_kind       r_a_kind;
    logic [31:0] r_a_reading;
    logic [31:0] r_a_low;
    logic [63:0] r_a_base;
    logic [63:0] r_a_op;

    // time stage
    logic        r_b_v;
    t_ext_item   r_b_item;

    logic [63:0] r_base;
    logic [31:0] r_cur_part;

    logic        w_ready_0;
    logic        w_ready_a;
    logic        w_ready_b;
    logic [31:0] w_pmask;
    logic [31:0] w_reading;
    logic [31:0] w_part;
    logic [31:0] w_delta;
    logic [63:0] n_base;
    logic [31:0] n_cur_part;

    assign w_ready_b = !r_b_v || i_ready;
    assign w_ready_a = !r_a_v || w_ready_b;
    assign w_ready_0 = !r_0_v || w_ready_a;
    assign o_ready   = w_ready_0;

    always_comb begin
        w_pmask    = i_partition_size - 32'd1;
        w_reading  = r_0_reading & WidthMask;
        w_part     = w_reading & ~w_pmask;
        w_delta    = (w_part - r_cur_part) & WidthMask;
        n_base     = r_base;
        n_cur_part = r_cur_part;
        if (w_part != r_cur_part) begin
            n_base     = r_base + {32'd0, w_delta & i_counter_mask};
            n_cur_part = w_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_0_v      <= 1'b0;
            r_a_v      <= 1'b0;
            r_b_v      <= 1'b0;
            r_base     <= 64'd0;
            r_cur_part <= 32'd0;
        end else begin
            if (w_ready_0) begin
                r_0_v <= i_valid;
            end
            if (w_ready_a) begin
                r_a_v <= r_0_v;
                if (r_0_v) begin
                    r_base     <= n_base;
                    r_cur_part <= n_cur_part;
                end
            end
            if (w_ready_b) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_0) begin
            r_0_kind    <= t_kind'(i_kind);
            r_0_reading <= i_lower_count;
            r_0_op      <= i_operand_value;
        end
        if (w_ready_a) begin
            r_a_kind    <= r_0_kind;
            r_a_reading <= w_reading;
            r_a_low     <= w_reading & w_pmask;
            r_a_base    <= n_base;
            r_a_op      <= r_0_op;
        end
        if (w_ready_b) begin
            r_b_item.kind       <= r_a_kind;
            r_b_item.reading    <= r_a_reading;
            r_b_item.operand    <= r_a_op;
            r_b_item.now        <= r_a_base + {32'd0, r_a_low};
            r_b_item.rel_target <= r_a_base + {32'd0, r_a_low} + r_a_op;
        end
    end

    assign o_valid = r_b_v;
    assign o_item  = r_b_item;

endmodule

[hdl/tes_alarm.sv]
// Alarm target update, expiry test and compare value generation.
`timescale 1ns / 1ps

module tes_alarm #(
    parameter int COUNTER_WIDTH = tes_pkg::CounterWidthDefault
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tes_pkg::t_ext_item  i_item,
    input  logic [31:0]         i_partition_size,
    input  logic [31:0]         i_counter_mask,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [63:0]         o_time_now,
    output logic                o_expired,
    output logic [31:0]         o_compare_value,
    output logic                o_compare_valid
);
    import tes_pkg::*;

    localparam logic [31:0] WidthMask = 32'((64'd1 << COUNTER_WIDTH) - 64'd1);

    logic        w_alarm;
    logic [63:0] r_target;

    // expiry stage
    logic        r_c_v;
    t_kind       r_c_kind;
    logic [31:0] r_c_reading;
    logic [63:0] r_c_now;
    logic [63:0] r_c_tgt;
    logic        r_c_exp;

    // result register
    logic        r_d_v;
    logic [63:0] r_d_now;
    logic        r_d_exp;
    logic [31:0] r_d_cmp;
    logic        r_d_cmp_v;

    logic        w_ready_c;
    logic        w_ready_d;
    logic        w_load_c;
    logic        w_arm;
    logic [63:0] w_tgt;
    logic        w_exp;
    logic [63:0] n_target;
    logic [63:0] w_diff;
    logic        w_far;
    logic [31:0] n_cmp;
    logic        w_cmp_v;

    assign w_ready_d = !r_d_v || i_ready;
    assign w_ready_c = !r_c_v || w_ready_d;
    assign o_ready   = w_ready_c;
    assign w_load_c  = i_valid && w_ready_c;
    assign w_arm     = i_item.kind != KIND_READ;

    always_comb begin
        case (i_item.kind)
            KIND_REL: w_tgt = i_item.rel_target;
            KIND_ABS: w_tgt = i_item.operand;
            default:  w_tgt = r_target;
        endcase
        w_exp    = w_arm && (w_tgt <= i_item.now);
        n_target = w_exp ? TargetUnset : w_tgt;
    end

    always_comb begin
        w_cmp_v = r_c_kind != KIND_READ;
        w_diff  = (r_c_tgt < r_c_now) ? 64'd0 : (r_c_tgt - r_c_now);
        w_far   = w_diff >= {32'd0, i_partition_size};
        if (!w_cmp_v) begin
            n_cmp = 32'd0;
        end else if (w_far) begin
            n_cmp = (r_c_reading + i_partition_size) & i_counter_mask & WidthMask;
        end else begin
            n_cmp = r_c_tgt[31:0] & i_counter_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v    <= 1'b0;
            r_d_v    <= 1'b0;
            r_target <= TargetUnset;
        end else begin
            if (w_ready_c) begin
                r_c_v <= i_valid;
            end
            if (w_load_c && w_arm) begin
                r_target <= n_target;
            end
            if (w_ready_d) begin
                r_d_v <= r_c_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready_c) begin
            r_c_kind    <= i_item.kind;
            r_c_reading <= i_item.reading;
            r_c_now     <= i_item.now;
            r_c_tgt     <= n_target;
            r_c_exp     <= w_exp;
        end
        if (w_ready_d) begin
            r_d_now   <= r_c_now;
            r_d_exp   <= r_c_exp;
            r_d_cmp   <= n_cmp;
            r_d_cmp_v <= w_cmp_v;
        end
    end

    assign w_alarm         = r_target != TargetUnset;
    assign o_valid         = r_d_v;
    assign o_time_now      = r_d_now;
    assign o_expired       = r_d_exp;
    assign o_compare_value = r_d_cmp;
    assign o_compare_valid = r_d_cmp_v;

    a_exp_cmp_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && r_d_exp |-> r_d_cmp_v)
        else $error("expiry reported on a read transfer");

    a_exp_unset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_c && w_exp |=> !w_alarm)
        else $error("alarm target not cleared after expiry");

    a_read_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_c && !w_arm |=> $stable(r_target))
        else $error("read transfer changed the alarm target");

    a_read_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_d_v && !r_d_cmp_v |-> (r_d_cmp == 32'd0) && !r_d_exp)
        else $error("read transfer carries compare data");

    a_armed_ahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_c_v && r_c_kind != KIND_READ |-> r_c_tgt >= r_c_now)
        else $error("pending target behind current time");

endmodule

[hdl/timer_extend_64bit_scheduler.sv]
// Top level: 64-bit timer extension with one alarm and configuration registers.
//
//  channel   direction  handshake                      payload
//  input     in         i_in_valid / o_in_ready        i_kind, i_lower_count, i_operand_value
//  result    out        o_out_valid / i_out_ready      o_time_now, o_expired,
//                                                      o_compare_value, o_compare_valid
//  config    in         i_cfg_valid / o_cfg_ready      i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while i_out_ready is high; each result passes through the
//  input register, partition stage, time stage, expiry stage and result register.
//  Synchronous reset clears the stage valid flags, the time base, the partition and
//  the alarm target; no clearing pass. A stalled result holds the full stages behind
//  it up to the first empty stage; items keep moving into empty stages.
`timescale 1ns / 1ps

module timer_extend_64bit_scheduler #(
    parameter int COUNTER_WIDTH = tes_pkg::CounterWidthDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_lower_count,
    input  logic [63:0] i_operand_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [63:0] o_time_now,
    output logic        o_expired,
    output logic [31:0] o_compare_value,
    output logic        o_compare_valid,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import tes_pkg::*;

    logic [31:0] r_partition_size;
    logic [31:0] r_counter_mask;
    logic        w_ext_valid;
    logic        w_ext_ready;
    t_ext_item   w_ext_item;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partition_size <= PartitionSizeReset;
            r_counter_mask   <= CounterMaskReset;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_PARTITION_SIZE: r_partition_size <= i_cfg_data;
                CFG_COUNTER_MASK:   r_counter_mask   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tes_extend #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_extend (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_in_valid),
        .o_ready          (o_in_ready),
        .i_kind           (i_kind),
        .i_lower_count    (i_lower_count),
        .i_operand_value  (i_operand_value),
        .i_partition_size (r_partition_size),
        .i_counter_mask   (r_counter_mask),
        .o_valid          (w_ext_valid),
        .i_ready          (w_ext_ready),
        .o_item           (w_ext_item)
    );

    tes_alarm #(
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_alarm (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (w_ext_valid),
        .o_ready          (w_ext_ready),
        .i_item           (w_ext_item),
        .i_partition_size (r_partition_size),
        .i_counter_mask   (r_counter_mask),
        .o_valid          (o_out_valid),
        .i_ready          (i_out_ready),
        .o_time_now       (o_time_now),
        .o_expired        (o_expired),
        .o_compare_value  (o_compare_value),
        .o_compare_valid  (o_compare_valid)
    );

endmodule
